### rtl/core/sine_tone_burst_mixer_macros.svh
// assertion macros for the sine tone burst mixer
`ifndef SINE_TONE_BURST_MIXER_MACROS_SVH
`define SINE_TONE_BURST_MIXER_MACROS_SVH

`ifndef SYNTH

// clocked check, switched off while reset is held
`define STBM_ASSERT_CLK(lbl, clk_s, rstn_s, prop_s, msg_s) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop_s) \
    else $error(msg_s);

// clocked check that also runs through reset
`define STBM_ASSERT_ALWAYS(lbl, clk_s, prop_s, msg_s) \
  lbl: assert property (@(posedge clk_s) prop_s) \
    else $error(msg_s);

`else

`define STBM_ASSERT_CLK(lbl, clk_s, rstn_s, prop_s, msg_s)
`define STBM_ASSERT_ALWAYS(lbl, clk_s, prop_s, msg_s)

`endif

`endif

### rtl/core/stbm_pkg.sv
// shared types, constants and table functions for the sine tone burst mixer
package stbm_pkg;

  // field and register widths
  localparam int SAMPLE_W    = 16;
  localparam int SINE_W      = 15;
  localparam int PHASE_W     = 32;
  localparam int AMP_W       = 15;
  localparam int POS_W       = 24;
  localparam int FADE_LEN_W  = 16;
  localparam int FADE_STEP_W = 17;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;

  // serial multiplier operand widths (b is kept even for 2-bit digits)
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // defaults for top level parameters
  localparam int SINE_DEPTH_DEF = 1024;
  localparam int COUNT_W_DEF    = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP   = 3'd5;

  // register reset values
  localparam logic [PHASE_W-1:0]     PHASE_STEP_RST   = 32'd25480000;
  localparam logic [AMP_W-1:0]       AMPLITUDE_RST    = 15'd3277;
  localparam logic [POS_W-1:0]       START_OFFSET_RST = 24'd0;
  localparam logic [POS_W-1:0]       TONE_LENGTH_RST  = 24'd11025;
  localparam logic [FADE_LEN_W-1:0]  FADE_LENGTH_RST  = 16'd441;
  localparam logic [FADE_STEP_W-1:0] FADE_STEP_RST    = 17'd149;

  // unity ramp gain in q1.16
  localparam logic [FADE_STEP_W-1:0] GAIN_UNITY = 17'h10000;

  // fixed point constants for the sine table, q2.30
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // input and result items
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mix_in;
    logic                       frame_start;
  } stbm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mix_out;
    logic                       tone_active;
  } stbm_out_t;

  // next odd power of x in q2.30, before the factorial divide
  function automatic logic [63:0] taylor_raise(input logic [63:0] term,
                                               input logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  // sine of x (q2.30 radians) as q0.15 magnitude, taylor series to x^17
  function automatic logic [SINE_W-1:0] sine_q15(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    term = x;
    sum  = x;
    term = taylor_raise(term, x) / 64'd6;
    sum  = sum - term;
    term = taylor_raise(term, x) / 64'd20;
    sum  = sum + term;
    term = taylor_raise(term, x) / 64'd42;
    sum  = sum - term;
    term = taylor_raise(term, x) / 64'd72;
    sum  = sum + term;
    term = taylor_raise(term, x) / 64'd110;
    sum  = sum - term;
    term = taylor_raise(term, x) / 64'd156;
    sum  = sum + term;
    term = taylor_raise(term, x) / 64'd210;
    sum  = sum - term;
    term = taylor_raise(term, x) / 64'd272;
    sum  = sum + term;
    v = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

### rtl/core/sine_tone_burst_mixer.sv
// top level of the sine tone burst mixer
// Passes 16-bit Q1.15 samples through and, inside a window of tone_length samples
// starting start_offset samples after a frame start, adds a sine tone made from a
// 32-bit phase accumulator, a quarter-wave table and an amplitude multiply, shaped by
// linear fade-in and fade-out ramps and saturated to 16 bits. One sample is worked on
// at a time. A sample inside the tone window goes through index and table read, then
// five products (amplitude, fade-in gain, fade-in scale, fade-out gain, fade-out scale)
// run one after another through a single multiplier that handles two bits per cycle,
// and the output register is loaded once it is empty or its result is taken. A sample
// outside the window goes straight to the output register load. The output register
// lets the next sample transfer in while a result still waits downstream.
`include "sine_tone_burst_mixer_macros.svh"

module sine_tone_burst_mixer
  import stbm_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  parameter int COUNT_WIDTH      = COUNT_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  stbm_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output stbm_out_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH_W    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IDX_PROD_W = 30 + DEPTH_W;
  localparam int CMP_W      = (COUNT_WIDTH > POS_W) ? COUNT_WIDTH : POS_W;
  localparam int SUM_W      = SAMPLE_W + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_IDX  = 3'd1;
  localparam logic [2:0] S_ROM  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // product steps
  localparam logic [2:0] STEP_AMP       = 3'd0;
  localparam logic [2:0] STEP_GIN       = 3'd1;
  localparam logic [2:0] STEP_APPLY_IN  = 3'd2;
  localparam logic [2:0] STEP_GOUT      = 3'd3;
  localparam logic [2:0] STEP_APPLY_OUT = 3'd4;

  // configuration registers
  logic [PHASE_W-1:0]     phase_step_r;
  logic [AMP_W-1:0]       amplitude_r;
  logic [POS_W-1:0]       start_offset_r;
  logic [POS_W-1:0]       tone_length_r;
  logic [FADE_LEN_W-1:0]  fade_length_r;
  logic [FADE_STEP_W-1:0] fade_step_r;

  // control state
  logic [2:0]             state_r;
  logic [2:0]             step_r;
  logic [COUNT_WIDTH-1:0] pos_r;
  logic [PHASE_W-1:0]     acc_r;
  logic                   out_valid_r;

  // per-sample working registers
  logic [SAMPLE_W-1:0]    x_r;
  logic                   active_r;
  logic [PHASE_W-1:0]     ph_r;
  logic [COUNT_WIDTH-1:0] n_r;
  logic                   fin_en_r;
  logic                   fout_en_r;
  logic [FADE_LEN_W-1:0]  m_lo_r;
  logic [DEPTH_W-1:0]     idx_r;
  logic [SINE_W-1:0]      mag_r;
  logic [FADE_STEP_W-1:0] gain_r;
  stbm_out_t              out_r;

  // window and phase selection at transfer in
  logic                   accept;
  logic [COUNT_WIDTH-1:0] p;
  logic [CMP_W-1:0]       p_x;
  logic [CMP_W-1:0]       so_x;
  logic [CMP_W-1:0]       tl_x;
  logic [CMP_W-1:0]       diff;
  logic                   in_win;
  logic [PHASE_W-1:0]     ph_sel;

  always_comb begin
    accept = in_valid && !in_stall;
    p      = in_data.frame_start ? '0 : pos_r;
    p_x    = CMP_W'(p);
    so_x   = CMP_W'(start_offset_r);
    tl_x   = CMP_W'(tone_length_r);
    diff   = p_x - so_x;
    in_win = (p != CNT_MAX) && (p_x >= so_x) && (diff < tl_x);
    ph_sel = (diff == '0) ? '0 : acc_r;
  end

  // ramp enables, fade-out index and table index
  logic [CMP_W-1:0]      n_x;
  logic [CMP_W-1:0]      fl_x;
  logic [CMP_W-1:0]      m_x;
  logic [IDX_PROD_W-1:0] idx_prod;
  logic [DEPTH_W-1:0]    idx_raw;
  logic [DEPTH_W-1:0]    idx_sel;

  always_comb begin
    n_x      = CMP_W'(n_r);
    fl_x     = CMP_W'(fade_length_r);
    m_x      = tl_x - CMP_W'(1) - n_x;
    idx_prod = IDX_PROD_W'(ph_r[29:0]) * IDX_PROD_W'(SINE_TABLE_DEPTH);
    idx_raw  = idx_prod[30 +: DEPTH_W];
    idx_sel  = ph_r[30] ? (DEPTH_W'(SINE_TABLE_DEPTH) - idx_raw) : idx_raw;
  end

  // sine table
  logic [SINE_W-1:0] sine_mag;

  stbm_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk     (clk),
    .addr    (idx_r),
    .rd_data (sine_mag)
  );

  // shared serial multiplier and its operand select
  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_prod;

  always_comb begin
    mul_start = (state_r == S_MUL);
    case (step_r)
      STEP_AMP: begin
        mul_a = MUL_A_W'(sine_mag);
        mul_b = MUL_B_W'(amplitude_r);
      end
      STEP_GIN: begin
        mul_a = MUL_A_W'(fade_step_r);
        mul_b = MUL_B_W'(n_r[FADE_LEN_W-1:0]);
      end
      STEP_GOUT: begin
        mul_a = MUL_A_W'(fade_step_r);
        mul_b = MUL_B_W'(m_lo_r);
      end
      STEP_APPLY_IN, STEP_APPLY_OUT: begin
        mul_a = MUL_A_W'(mag_r);
        mul_b = MUL_B_W'(gain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  stbm_serial_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  // rounding of products and gain clamp
  logic [30:0]            amp_sum;
  logic [31:0]            fade_sum;
  logic                   gain_en;
  logic [FADE_STEP_W-1:0] gain_sel;

  always_comb begin
    amp_sum  = 31'(mul_prod[29:0]) + 31'd16384;
    fade_sum = mul_prod[31:0] + 32'd32768;
    gain_en  = (step_r == STEP_GIN) ? fin_en_r : fout_en_r;
    if (!gain_en) begin
      gain_sel = GAIN_UNITY;
    end else if (mul_prod > MUL_P_W'(GAIN_UNITY)) begin
      gain_sel = GAIN_UNITY;
    end else begin
      gain_sel = mul_prod[FADE_STEP_W-1:0];
    end
  end

  // signed sum and saturation
  logic [SUM_W-1:0]    tone_x;
  logic [SUM_W-1:0]    tone_s;
  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] sat;
  logic                out_load;

  always_comb begin
    tone_x = SUM_W'(mag_r);
    tone_s = ph_r[31] ? (SUM_W'(0) - tone_x) : tone_x;
    sum    = {x_r[SAMPLE_W-1], x_r} + (active_r ? tone_s : SUM_W'(0));
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      sat = sum[SUM_W-1] ? S_MIN : S_MAX;
    end else begin
      sat = sum[SAMPLE_W-1:0];
    end
    out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  end

  // configuration, sequencer, position and phase state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= PHASE_STEP_RST;
      amplitude_r    <= AMPLITUDE_RST;
      start_offset_r <= START_OFFSET_RST;
      tone_length_r  <= TONE_LENGTH_RST;
      fade_length_r  <= FADE_LENGTH_RST;
      fade_step_r    <= FADE_STEP_RST;
      state_r        <= S_IDLE;
      step_r         <= STEP_AMP;
      pos_r          <= '0;
      acc_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PHASE_STEP:   phase_step_r   <= cfg_wdata[PHASE_W-1:0];
          REG_AMPLITUDE:    amplitude_r    <= cfg_wdata[AMP_W-1:0];
          REG_START_OFFSET: start_offset_r <= cfg_wdata[POS_W-1:0];
          REG_TONE_LENGTH:  tone_length_r  <= cfg_wdata[POS_W-1:0];
          REG_FADE_LENGTH:  fade_length_r  <= cfg_wdata[FADE_LEN_W-1:0];
          REG_FADE_STEP:    fade_step_r    <= cfg_wdata[FADE_STEP_W-1:0];
          default: ;
        endcase
      end

      // output register fills on load, empties on transfer out
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            pos_r <= (p != CNT_MAX) ? (p + COUNT_WIDTH'(1)) : CNT_MAX;
            if (in_win) begin
              acc_r   <= ph_sel + phase_step_r;
              state_r <= S_IDX;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_IDX: begin
          state_r <= S_ROM;
        end
        S_ROM: begin
          step_r  <= STEP_AMP;
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            if (step_r == STEP_APPLY_OUT) begin
              state_r <= S_OUT;
            end else begin
              step_r  <= step_r + 3'd1;
              state_r <= S_MUL;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // sample payload through the steps
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && accept) begin
      x_r      <= in_data.mix_in;
      active_r <= in_win;
      ph_r     <= ph_sel;
      n_r      <= diff[COUNT_WIDTH-1:0];
    end
    if (state_r == S_IDX) begin
      fin_en_r  <= n_x < fl_x;
      fout_en_r <= m_x < fl_x;
      m_lo_r    <= m_x[FADE_LEN_W-1:0];
      idx_r     <= idx_sel;
    end
    if ((state_r == S_WAIT) && mul_done) begin
      case (step_r)
        STEP_AMP:                      mag_r  <= amp_sum[29:15];
        STEP_GIN, STEP_GOUT:           gain_r <= gain_sel;
        STEP_APPLY_IN, STEP_APPLY_OUT: mag_r  <= fade_sum[30:16];
        default: ;
      endcase
    end
    if (out_load) begin
      out_r.mix_out     <= sat;
      out_r.tone_active <= active_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `STBM_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid, "out_valid set after reset")
  `STBM_ASSERT_CLK(a_mul_done_in_wait, clk, rst_n, mul_done |-> (state_r == S_WAIT), "product finished outside wait state")
  `STBM_ASSERT_CLK(a_pos_monotonic, clk, rst_n, (accept && !in_data.frame_start) |=> (pos_r >= $past(pos_r)), "position count went back without frame start")
  `STBM_ASSERT_CLK(a_fade_no_growth, clk, rst_n, (state_r == S_WAIT && mul_done && (step_r == STEP_APPLY_IN || step_r == STEP_APPLY_OUT)) |=> (mag_r <= $past(mag_r)), "ramp gain raised the tone magnitude")

endmodule

### rtl/core/stbm_serial_mul.sv
// radix-4 digit serial unsigned multiplier, two multiplier bits per cycle
module stbm_serial_mul
  import stbm_pkg::*;
#(
  parameter int A_W = MUL_A_W,
  parameter int B_W = MUL_B_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] product
);

  localparam int STEPS = B_W / 2;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic [A_W-1:0]   a_r;
  logic [A_W-1:0]   hi_r;
  logic [B_W-1:0]   lo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [A_W+1:0] a_x;
  logic [A_W+1:0] part0;
  logic [A_W+1:0] part1;
  logic [A_W+1:0] dsum;

  // add a times the low digit to the upper half
  always_comb begin
    a_x   = {2'b00, a_r};
    part0 = lo_r[0] ? a_x : '0;
    part1 = lo_r[1] ? {a_x[A_W:0], 1'b0} : '0;
    dsum  = {2'b00, hi_r} + part0 + part1;
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // partial product shifts right two bits a step
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= dsum[A_W+1:2];
      lo_r <= {dsum[1:0], lo_r[B_W-1:2]};
    end
  end

  assign done    = done_r;
  assign product = {hi_r, lo_r};

endmodule

### rtl/core/stbm_sine_rom.sv
// quarter-wave sine table with registered read
module stbm_sine_rom
  import stbm_pkg::*;
#(
  parameter  int DEPTH  = SINE_DEPTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  output logic [SINE_W-1:0] rd_data
);

  logic [SINE_W-1:0] rom [DEPTH+1];
  logic [SINE_W-1:0] data_r;

  // entry i holds sin(pi*i/(2*depth)), worked out at elaboration
  for (genvar gi = 0; gi <= DEPTH; gi++) begin : g_entry
    localparam logic [63:0] X = (PI_Q30 * 64'(gi)) / (64'd2 * 64'(DEPTH));
    assign rom[gi] = sine_q15(X);
  end

  // registered read
  always_ff @(posedge clk) begin
    data_r <= rom[addr];
  end

  assign rd_data = data_r;

endmodule
